### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

### hdl/cbp_pkg.sv
// Shared types, codes and tactic tables of the cache budget partitioner.
`default_nettype none

package cbp_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_ACTIVITY = 3'd2,
        OP_STATS    = 3'd3,
        OP_REVISE   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        TAC_EVEN      = 3'd0,
        TAC_CUR_HEAD  = 3'd1,
        TAC_CUR       = 3'd2,
        TAC_LIVE_HEAD = 3'd3,
        TAC_LIVE      = 3'd4
    } t_tactic;

    localparam logic [1:0] CFG_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_LOW_END   = 2'd2;
    localparam logic [1:0] CFG_DEAD_CAP  = 2'd3;

    localparam logic [2:0] LAST_STEP = 3'd4;

    localparam int CAP_W = 48;
    localparam int DL_W  = 47;
    localparam int BYTES_W = 40;
    localparam int TIME_W  = 32;

    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] last;
    } t_meta;

    typedef struct packed {
        logic [BYTES_W-1:0] live;
        logic [BYTES_W-1:0] dead;
    } t_bytes;

    function automatic t_tactic active_plan(input logic [2:0] step);
        t_tactic tac;
        unique case (step)
            3'd0:    tac = TAC_CUR_HEAD;
            3'd1:    tac = TAC_CUR_HEAD;
            3'd2:    tac = TAC_LIVE_HEAD;
            3'd3:    tac = TAC_LIVE;
            default: tac = TAC_EVEN;
        endcase
        return tac;
    endfunction

    function automatic t_tactic inactive_plan(input logic [2:0] step);
        t_tactic tac;
        unique case (step)
            3'd0:    tac = TAC_CUR;
            3'd1:    tac = TAC_LIVE;
            default: tac = TAC_EVEN;
        endcase
        return tac;
    endfunction

endpackage

`default_nettype wire

### hdl/cache_budget_partitioner_core.sv
// Top level of the cache budget partitioner: command decode, sequencer, grant datapath.
// Usage:
//   Commands are accepted when i_start is high and o_busy is low. Add, remove,
//   activity and stats take effect in the accepting cycle and leave o_busy low.
//   Revise raises o_busy and runs: a scan of all slots that ages idle slots
//   and sums byte counts, a tactic search that stops at the first tactic that
//   fits or at the last step, three divisions on the shared bit-serial divider,
//   and an emit pass over all slots twice.
//   Grants appear one per cycle at most, each for exactly one cycle with
//   o_strobe high; o_last_grant marks the final one. The receiver cannot stall.
//   A revise with no valid slot gives no grant.
//   Configuration writes use i_cfg_valid / o_cfg_ready (always ready) and must
//   be made only while the block is idle; the block does not enforce this.
//   Reset (synchronous, active low) clears all slot valid bits and loads the
//   default register values; the slot memories need no clearing pass.
`default_nettype none

module cache_budget_partitioner_core #(
    parameter int MAX_CLIENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [3:0]  i_client_id,
    input  wire logic [39:0] i_live_bytes_in,
    input  wire logic [39:0] i_dead_bytes_in,
    input  wire logic [31:0] i_now,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    output logic             o_strobe,
    output logic [3:0]       o_grant_client,
    output logic [47:0]      o_granted_capacity,
    output logic [46:0]      o_dead_capacity_limit,
    output logic             o_grant_was_active,
    output logic             o_last_grant
);

    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W = $clog2(MAX_CLIENTS + 2);
    localparam int SUM_W = cbp_pkg::BYTES_W + $clog2(MAX_CLIENTS + 1);
    localparam int RES_W = SUM_W + 2;
    localparam int CMP_W = (RES_W + 1 > cbp_pkg::CAP_W) ? RES_W + 1 : cbp_pkg::CAP_W;
    localparam int CS_W  = ((RES_W > cbp_pkg::CAP_W) ? RES_W : cbp_pkg::CAP_W) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLIENTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_DRAIN, S_TAC_CALC, S_TAC_CMP,
        S_DIV_I, S_DIV_A, S_DIV_E, S_EMIT, S_EMIT_DRAIN
    } t_state;

    function automatic logic [RES_W-1:0] reserve(input cbp_pkg::t_tactic tac,
                                                 input logic [SUM_W-1:0] l,
                                                 input logic [SUM_W-1:0] d);
        logic [SUM_W:0]   base;
        logic [SUM_W+2:0] tri3;
        logic [RES_W-1:0] res;
        if (tac == cbp_pkg::TAC_CUR_HEAD || tac == cbp_pkg::TAC_CUR) begin
            base = {1'b0, l} + {1'b0, d};
        end else begin
            base = {1'b0, l};
        end
        tri3 = {2'b00, base} + {1'b0, base, 1'b0};
        case (tac)
            cbp_pkg::TAC_CUR_HEAD, cbp_pkg::TAC_LIVE_HEAD: res = tri3[SUM_W+2:1];
            cbp_pkg::TAC_CUR, cbp_pkg::TAC_LIVE:           res = {1'b0, base};
            default:                                       res = '0;
        endcase
        return res;
    endfunction

    t_state r_state;

    // configuration
    logic [47:0] r_limit;
    logic [31:0] r_thr;
    logic        r_low;
    logic [39:0] r_dcl;

    logic [MAX_CLIENTS-1:0] r_valid;

    logic            accept;
    cbp_pkg::t_op    op;
    logic            in_range;
    logic [IDX_W-1:0] id_a;
    logic            id_valid;

    // sequencer
    logic [IDX_W-1:0] r_idx;
    logic             r_ph;
    logic [2:0]       r_step;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_k;

    // read pipeline
    logic             r_rd_v;
    logic             r_rd_emit;
    logic             r_rd_ph;
    logic [IDX_W-1:0] r_rd_idx;
    cbp_pkg::t_meta   rd_meta;
    cbp_pkg::t_bytes  rd_bytes;

    // scan stage
    logic        sc_hit;
    logic [31:0] idle;
    logic        went_idle;
    logic        r_p1_v;
    logic        r_p1_act;
    logic [39:0] r_p1_live;
    logic [39:0] r_p1_dead;
    logic [SUM_W-1:0] r_al, r_ad, r_il, r_id;
    logic [CNT_W-1:0] r_na, r_ni;

    // tactic and shares
    logic [RES_W-1:0] r_a_size, r_i_size;
    cbp_pkg::t_tactic r_tac_a, r_tac_i;
    logic [CMP_W-1:0] need;
    logic             fits;
    logic [47:0]      total_next;
    logic [47:0]      r_total;
    logic [47:0]      r_iex;
    logic [47:0]      iex_next;
    logic [47:0]      r_each_a, r_each_i;

    // divider
    logic             r_div_start;
    logic [47:0]      r_div_n;
    logic [CNT_W-1:0] r_div_d;
    logic             div_done;
    logic [47:0]      div_q;

    // emit stages
    logic             em_hit;
    logic             r_e1_v, r_e1_ph;
    logic [IDX_W-1:0] r_e1_idx;
    logic [RES_W-1:0] r_e1_res;
    logic             r_e2_v, r_e2_ph;
    logic [IDX_W-1:0] r_e2_idx;
    logic [47:0]      r_e2_cap;
    logic [CS_W-1:0]  cap_sum;
    logic [46:0]      dl_half;

    // memory ports
    logic            meta_we, bytes_we;
    logic [IDX_W-1:0] meta_waddr;
    cbp_pkg::t_meta  meta_wdata;
    cbp_pkg::t_bytes bytes_wdata;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;
    assign op          = cbp_pkg::t_op'(i_operation);
    assign in_range    = 32'(i_client_id) < MAX_CLIENTS;
    assign id_a        = IDX_W'(i_client_id);
    assign id_valid    = in_range && r_valid[id_a];

    // scan: age the slot just read
    assign sc_hit    = r_rd_v && !r_rd_emit && r_valid[r_rd_idx];
    assign idle      = r_now - rd_meta.last;
    assign went_idle = rd_meta.active && (idle >= r_thr);

    // memory write steering
    always_comb begin
        meta_we     = 1'b0;
        meta_waddr  = id_a;
        meta_wdata  = '{active: 1'b1, last: i_now};
        bytes_we    = 1'b0;
        bytes_wdata = '{live: i_live_bytes_in, dead: i_dead_bytes_in};
        if (accept && in_range) begin
            case (op)
                cbp_pkg::OP_ADD: begin
                    meta_we     = 1'b1;
                    bytes_we    = 1'b1;
                    bytes_wdata = '0;
                end
                cbp_pkg::OP_ACTIVITY: meta_we  = id_valid;
                cbp_pkg::OP_STATS:    bytes_we = id_valid;
                default: ;
            endcase
        end
        if (sc_hit && went_idle) begin
            meta_we    = 1'b1;
            meta_waddr = r_rd_idx;
            meta_wdata = '{active: 1'b0, last: rd_meta.last};
        end
    end

    cbp_slot_mem #(
        .DEPTH (MAX_CLIENTS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk         (i_clk),
        .i_meta_we     (meta_we),
        .i_meta_waddr  (meta_waddr),
        .i_meta_wdata  (meta_wdata),
        .i_bytes_we    (bytes_we),
        .i_bytes_waddr (id_a),
        .i_bytes_wdata (bytes_wdata),
        .i_raddr       (r_idx),
        .o_meta_rdata  (rd_meta),
        .o_bytes_rdata (rd_bytes)
    );

    cbp_divider #(
        .NUM_W (48),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_n),
        .i_divisor  (r_div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign need       = CMP_W'(r_a_size) + CMP_W'(r_i_size);
    assign fits       = need <= CMP_W'(r_limit);
    assign total_next = 48'(CMP_W'(r_limit) - need);
    assign iex_next   = (r_ni != '0) ? div_q : '0;

    assign em_hit  = r_rd_v && r_rd_emit && r_valid[r_rd_idx] && (rd_meta.active == !r_rd_ph);
    assign cap_sum = CS_W'(r_e1_ph ? r_each_i : r_each_a) + CS_W'(r_e1_res);
    assign dl_half = r_e2_cap[47:1];

    // slot valid bits and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_limit <= 48'd8388608;
            r_thr   <= 32'd300;
            r_low   <= 1'b0;
            r_dcl   <= 40'd524288;
        end else begin
            if (accept && in_range) begin
                if (op == cbp_pkg::OP_ADD) begin
                    r_valid[id_a] <= 1'b1;
                end else if (op == cbp_pkg::OP_REMOVE) begin
                    r_valid[id_a] <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    cbp_pkg::CFG_LIMIT:     r_limit <= i_cfg_data;
                    cbp_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data[31:0];
                    cbp_pkg::CFG_LOW_END:   r_low   <= i_cfg_data[0];
                    cbp_pkg::CFG_DEAD_CAP:  r_dcl   <= i_cfg_data[39:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
        end else begin
            r_p1_v    <= sc_hit;
            r_p1_act  <= rd_meta.active && !went_idle;
            r_p1_live <= rd_bytes.live;
            r_p1_dead <= rd_bytes.dead;

            if (accept && op == cbp_pkg::OP_REVISE) begin
                r_al <= '0;
                r_ad <= '0;
                r_il <= '0;
                r_id <= '0;
                r_na <= '0;
                r_ni <= '0;
            end else if (r_p1_v) begin
                if (r_p1_act) begin
                    r_al <= r_al + SUM_W'(r_p1_live);
                    r_ad <= r_ad + SUM_W'(r_p1_dead);
                    r_na <= r_na + 1'b1;
                end else begin
                    r_il <= r_il + SUM_W'(r_p1_live);
                    r_id <= r_id + SUM_W'(r_p1_dead);
                    r_ni <= r_ni + 1'b1;
                end
            end

            r_e1_v   <= em_hit;
            r_e1_ph  <= r_rd_ph;
            r_e1_idx <= r_rd_idx;
            r_e1_res <= reserve(r_rd_ph ? r_tac_i : r_tac_a,
                                SUM_W'(rd_bytes.live), SUM_W'(rd_bytes.dead));

            r_e2_v   <= r_e1_v;
            r_e2_ph  <= r_e1_ph;
            r_e2_idx <= r_e1_idx;
            // saturate the capacity
            r_e2_cap <= (cap_sum[CS_W-1:48] != '0) ? '1 : cap_sum[47:0];
        end
    end

    // sequencer and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_v      <= 1'b0;
            r_div_start <= 1'b0;
            o_strobe    <= 1'b0;
        end else begin
            r_rd_v      <= (r_state == S_SCAN) || (r_state == S_EMIT);
            r_rd_emit   <= (r_state == S_EMIT);
            r_rd_ph     <= r_ph;
            r_rd_idx    <= r_idx;
            // launch a division on tactic choice and after the first and second finish
            r_div_start <= ((r_state == S_TAC_CMP) && (fits || r_step == cbp_pkg::LAST_STEP))
                        || (((r_state == S_DIV_I) || (r_state == S_DIV_A)) && div_done);

            o_strobe              <= r_e2_v;
            o_grant_client        <= 4'(r_e2_idx);
            o_granted_capacity    <= r_e2_cap;
            o_dead_capacity_limit <= (r_low && dl_half > 47'(r_dcl)) ? 47'(r_dcl) : dl_half;
            o_grant_was_active    <= !r_e2_ph;
            o_last_grant          <= CNT_W'(r_k + 1'b1) == CNT_W'(r_na + r_ni);
            if (r_e2_v) begin
                r_k <= r_k + 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && op == cbp_pkg::OP_REVISE) begin
                        r_idx   <= '0;
                        r_now   <= i_now;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_SCAN_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN_DRAIN: begin
                    if (!r_rd_v && !r_p1_v) begin
                        r_step  <= '0;
                        r_state <= S_TAC_CALC;
                    end
                end
                S_TAC_CALC: begin
                    r_tac_a  <= cbp_pkg::active_plan(r_step);
                    r_tac_i  <= cbp_pkg::inactive_plan(r_step);
                    r_a_size <= reserve(cbp_pkg::active_plan(r_step), r_al, r_ad);
                    r_i_size <= reserve(cbp_pkg::inactive_plan(r_step), r_il, r_id);
                    r_state  <= S_TAC_CMP;
                end
                S_TAC_CMP: begin
                    if (fits || r_step == cbp_pkg::LAST_STEP) begin
                        r_total     <= total_next;
                        r_div_n     <= total_next;
                        r_div_d     <= CNT_W'(r_na + 1'b1);
                        r_state     <= S_DIV_I;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_TAC_CALC;
                    end
                end
                S_DIV_I: begin
                    if (div_done) begin
                        r_iex       <= iex_next;
                        r_div_n     <= r_total - iex_next;
                        r_div_d     <= r_na;
                        r_state     <= S_DIV_A;
                    end
                end
                S_DIV_A: begin
                    if (div_done) begin
                        r_each_a    <= div_q;
                        r_div_n     <= r_iex;
                        r_div_d     <= r_ni;
                        r_state     <= S_DIV_E;
                    end
                end
                S_DIV_E: begin
                    if (div_done) begin
                        r_each_i <= div_q;
                        r_idx    <= '0;
                        r_ph     <= 1'b0;
                        r_k      <= '0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx <= '0;
                        if (r_ph) begin
                            r_state <= S_EMIT_DRAIN;
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT_DRAIN: begin
                    if (!r_rd_v && !r_e1_v && !r_e2_v) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"

    `ASSERT_PROP(a_strobe_busy, i_clk, i_rst_n, o_strobe |-> o_busy, "grant while idle")
    `ASSERT_PROP(a_pipe_busy, i_clk, i_rst_n, (r_rd_v || r_e1_v || r_e2_v) |-> o_busy, "pipeline live while idle")
    `ASSERT_PROP(a_last_ends, i_clk, i_rst_n, (o_strobe && o_last_grant) |=> !o_strobe, "grant after last")

endmodule

`default_nettype wire

### hdl/cbp_slot_mem.sv
// Slot table: timing memory and byte count memory, one shared read address.
`default_nettype none

module cbp_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_meta_we,
    input  wire logic [AW-1:0]   i_meta_waddr,
    input  wire cbp_pkg::t_meta  i_meta_wdata,
    input  wire logic            i_bytes_we,
    input  wire logic [AW-1:0]   i_bytes_waddr,
    input  wire cbp_pkg::t_bytes i_bytes_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output cbp_pkg::t_meta       o_meta_rdata,
    output cbp_pkg::t_bytes      o_bytes_rdata
);

    cbp_pkg::t_meta  r_meta_mem  [DEPTH];
    cbp_pkg::t_bytes r_bytes_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta_mem[i_meta_waddr] <= i_meta_wdata;
        end
        o_meta_rdata <= r_meta_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_bytes_we) begin
            r_bytes_mem[i_bytes_waddr] <= i_bytes_wdata;
        end
        o_bytes_rdata <= r_bytes_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/cbp_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module cbp_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quotient
);

    localparam int CW = $clog2(NUM_W + 1);

    logic            r_run;
    logic [CW-1:0]   r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]  trial;
    logic            fits;

    assign trial = {r_rem, o_quotient[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_start && r_run && (r_cnt == CW'(NUM_W - 1));
            if (i_start) begin
                r_run      <= 1'b1;
                r_cnt      <= '0;
                r_rem      <= '0;
                r_den      <= i_divisor;
                o_quotient <= i_dividend;
            end else if (r_run) begin
                r_rem      <= fits ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
                o_quotient <= {o_quotient[NUM_W-2:0], fits};
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    `include "assert_macros.svh"

    `ASSERT_PROP(a_done_ends_run, i_clk, i_rst_n, o_done |-> !r_run, "done while running")
    `ASSERT_PROP(a_run_after_start, i_clk, i_rst_n, i_start |=> r_run, "start did not run")
    `ASSERT_PROP(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "done held two cycles")

endmodule

`default_nettype wire
